### rtl/calendar_minute_counter_assert.svh
// Assertion macros for the calendar minute counter.
`ifndef CALENDAR_MINUTE_COUNTER_ASSERT_SVH
`define CALENDAR_MINUTE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMC_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cmc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CMC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cmc: next-cycle check failed");

`endif

### rtl/cmc_pkg.sv
// Shared types, constants and calendar functions for the calendar minute counter.
`timescale 1ns / 1ps

package cmc_pkg;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   localparam logic [5:0]  MINUTE_LAST = 6'd59;
   localparam logic [4:0]  HOUR_LAST   = 5'd23;
   localparam logic [4:0]  HOUR_PM     = 5'd12;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [13:0] YEAR_LAST   = 14'd9999;
   localparam logic [4:0]  DAYS_FEB    = 5'd28;
   localparam logic [4:0]  DAYS_LEAP   = 5'd29;
   localparam logic [4:0]  DAYS_SHORT  = 5'd30;
   localparam logic [4:0]  DAYS_LONG   = 5'd31;

   // floor(y/25) = (y * 5243) >> 17, exact for every 14-bit y
   localparam logic [27:0] DIV25_MUL   = 28'd5243;
   localparam int          DIV25_SHIFT = 17;
   localparam logic [13:0] DIV25_DIV   = 14'd25;

   typedef struct packed {
      logic        valid;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } cal_type;

   localparam cal_type CAL_RESET = '{
      valid:  1'b0,
      year:   14'd0,
      month:  4'd1,
      day:    5'd1,
      hour:   5'd0,
      minute: 6'd0
   };

   // Gregorian rule: div by 400 = div by 16 and 25; div by 100 = div by 4 and 25
   function automatic logic is_leap(input logic [13:0] y);
      logic [27:0] prod;
      logic [9:0]  quot;
      logic [13:0] back;
      logic        div25;
      prod  = 28'(y) * DIV25_MUL;
      quot  = prod[DIV25_SHIFT +: 10];
      back  = 14'({4'd0, quot} * DIV25_DIV);
      div25 = (back == y);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   // Months outside 1..12 count as long months
   function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      len = DAYS_LONG;
      if (m == MONTH_FEB) begin
         len = leap ? DAYS_LEAP : DAYS_FEB;
      end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = DAYS_SHORT;
      end
      return len;
   endfunction

endpackage

### rtl/calendar_minute_counter.sv
// Top level of the calendar minute counter: input register, time state, result register.
//
//   channel | handshake            | payload
//   req     | req_valid, req_stall | req_type, req_load_*
//   rsp     | rsp_valid, rsp_stall | rsp_out_*
//
// One transaction per cycle sustained while rsp_stall is low; a request passes
// the input register, then the result register, around one carry chain.
// Reset is synchronous: time goes invalid at 0000-01-01 00:00, both stages empty.
// A stalled result holds the input stage; req_stall rises only when both stages are full.
`timescale 1ns / 1ps
`include "calendar_minute_counter_assert.svh"

module calendar_minute_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic        req_load_valid,
   input  logic [13:0] req_load_year,
   input  logic [3:0]  req_load_month,
   input  logic [4:0]  req_load_day,
   input  logic [4:0]  req_load_hour,
   input  logic [5:0]  req_load_minute,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic        rsp_out_pm
);
   import cmc_pkg::*;

   logic    s1_vld_ff;
   logic    s1_load_ff;
   cal_type s1_cal_ff;
   cal_type cal_ff;
   cal_type cal_in;
   logic    out_vld_ff;
   cal_type out_cal_ff;
   logic    out_pm_ff;
   logic    advance;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !advance;

   cmc_step u_step (
      .load     (s1_load_ff),
      .load_cal (s1_cal_ff),
      .cur      (cal_ff),
      .nxt      (cal_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_vld_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_load_ff       <= req_type;
         s1_cal_ff.valid  <= req_load_valid;
         s1_cal_ff.year   <= req_load_year;
         s1_cal_ff.month  <= req_load_month;
         s1_cal_ff.day    <= req_load_day;
         s1_cal_ff.hour   <= req_load_hour;
         s1_cal_ff.minute <= req_load_minute;
      end
   end

   // State commits together with the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         cal_ff     <= CAL_RESET;
      end else if (advance) begin
         out_vld_ff <= s1_vld_ff;
         if (s1_vld_ff) begin
            cal_ff <= cal_in;
         end
      end
      if (advance && s1_vld_ff) begin
         out_cal_ff <= cal_in;
         out_pm_ff  <= cal_in.valid && (cal_in.hour >= HOUR_PM);
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_valid  = out_cal_ff.valid;
   assign rsp_out_year   = out_cal_ff.year;
   assign rsp_out_month  = out_cal_ff.month;
   assign rsp_out_day    = out_cal_ff.day;
   assign rsp_out_hour   = out_cal_ff.hour;
   assign rsp_out_minute = out_cal_ff.minute;
   assign rsp_out_pm     = out_pm_ff;

   `CMC_ASSERT_IMPLIES(a_invalid_is_reset, !cal_ff.valid, cal_ff == CAL_RESET)
   `CMC_ASSERT_IMPLIES(a_pm_consistent, out_vld_ff && out_pm_ff,
                       out_cal_ff.valid && (out_cal_ff.hour >= HOUR_PM))
   `CMC_ASSERT_NEXT(a_result_tracks_state, advance && s1_vld_ff, out_vld_ff && (out_cal_ff == cal_ff))

endmodule

### rtl/cmc_step.sv
// Next-state logic: applies one tick or load to the held date and time.
`timescale 1ns / 1ps

module cmc_step (
   input  logic             load,
   input  cmc_pkg::cal_type load_cal,
   input  cmc_pkg::cal_type cur,
   output cmc_pkg::cal_type nxt
);
   import cmc_pkg::*;

   logic       min_wrap;
   logic       hour_wrap;
   logic       day_wrap;
   logic       month_wrap;
   logic       year_ovf;
   logic [5:0] day_inc;
   logic [4:0] month_len;

   assign month_len  = days_in(cur.month, is_leap(cur.year));
   assign day_inc    = {1'b0, cur.day} + 6'd1;
   assign min_wrap   = (cur.minute >= MINUTE_LAST);
   assign hour_wrap  = (cur.hour >= HOUR_LAST);
   assign day_wrap   = (day_inc > {1'b0, month_len});
   assign month_wrap = (cur.month >= MONTH_LAST);
   assign year_ovf   = (cur.year >= YEAR_LAST);

   always_comb begin
      nxt = cur;
      if (load == REQ_LOAD) begin
         nxt = load_cal.valid ? load_cal : CAL_RESET;
      end else if (cur.valid) begin
         nxt.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
         if (min_wrap) begin
            nxt.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
            if (hour_wrap) begin
               nxt.day = day_wrap ? 5'd1 : day_inc[4:0];
               if (day_wrap) begin
                  nxt.month = month_wrap ? 4'd1 : cur.month + 4'd1;
                  if (month_wrap) begin
                     if (year_ovf) begin
                        // past the last year: pin to the final minute
                        nxt.year   = YEAR_LAST;
                        nxt.month  = MONTH_LAST;
                        nxt.day    = DAYS_LONG;
                        nxt.hour   = HOUR_LAST;
                        nxt.minute = MINUTE_LAST;
                     end else begin
                        nxt.year = cur.year + 14'd1;
                     end
                  end
               end
            end
         end
      end
   end

endmodule
